FILE: hdl/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants of the advection stencil right-hand-side core.
// ----------------------------------------------------------------------------
package asr_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [23:0] coef_t;
  typedef logic signed [31:0] rhs_t;
  typedef logic        [9:0]  row_idx_t;
  typedef logic        [7:0]  col_idx_t;
  typedef logic        [10:0] row_cnt_t;
  typedef logic        [8:0]  col_cnt_t;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SCHEME_MODE = 3'd0;
  localparam reg_idx_t REG_COEF_X      = 3'd1;
  localparam reg_idx_t REG_COEF_Y      = 3'd2;
  localparam reg_idx_t REG_ROW_COUNT   = 3'd3;
  localparam reg_idx_t REG_COL_COUNT   = 3'd4;

  localparam int MIN_DIM = 3;

  localparam int SHIFT_UPWIND  = 12;
  localparam int SHIFT_CENTRAL = 13;

  typedef struct packed {
    diff_t    dxd;
    diff_t    dyd;
    logic     central;
    row_idx_t row_index;
    col_idx_t col_index;
    logic     last;
  } rhs_item_t;

endpackage

FILE: hdl/asr_if.sv
// ----------------------------------------------------------------------------
// asr stream interfaces
// Valid/ready channels for input samples and right-hand-side results.
// ----------------------------------------------------------------------------
interface asr_sample_if;
  logic              valid;
  logic              ready;
  asr_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface asr_result_if;
  logic               valid;
  logic               ready;
  asr_pkg::rhs_t      rhs_value;
  asr_pkg::row_idx_t  row_index;
  asr_pkg::col_idx_t  col_index;
  logic               last;

  modport source (output valid, output rhs_value, output row_index, output col_index,
                  output last, input ready);
  modport sink   (input valid, input rhs_value, input row_index, input col_index,
                  input last, output ready);
endinterface

FILE: hdl/asr_ram.sv
// ----------------------------------------------------------------------------
// asr_ram
// Simple dual-port RAM, one write and one read port, registered read-old data.
// ----------------------------------------------------------------------------
module asr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/asr_cell.sv
// ----------------------------------------------------------------------------
// asr_cell
// One stencil row: two window taps and, optionally, the line buffer that
// delays this row's samples by one grid row for the next cell.
// ----------------------------------------------------------------------------
module asr_cell #(
  parameter int DEPTH    = 256,
  parameter bit HAS_LINE = 1'b1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  asr_pkg::sample_t         din,
  output asr_pkg::sample_t         tap_prev,
  output asr_pkg::sample_t         tap_cur,
  output asr_pkg::sample_t         line_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_prev <= '0;
      tap_cur  <= '0;
    end else if (adv) begin
      tap_prev <= tap_cur;
      tap_cur  <= din;
    end
  end

  if (HAS_LINE) begin : g_line
    asr_ram #(
      .WIDTH ($bits(asr_pkg::sample_t)),
      .DEPTH (DEPTH)
    ) u_line (
      .clk   (clk),
      .we    (adv),
      .waddr (wr_addr),
      .wdata (din),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (line_out)
    );
  end else begin : g_noline
    assign line_out = '0;
  end

endmodule

FILE: hdl/asr_rhs_pipe.sv
// ----------------------------------------------------------------------------
// asr_rhs_pipe
// Coefficient products, sum, negate and floor shift, with the result register.
// ----------------------------------------------------------------------------
module asr_rhs_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  asr_pkg::coef_t        coef_x,
  input  asr_pkg::coef_t        coef_y,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  asr_pkg::rhs_item_t    in_item,
  asr_result_if.source          result
);

  localparam int PW = $bits(asr_pkg::coef_t) + $bits(asr_pkg::diff_t);
  localparam int SW = PW + 1;

  logic                s2_valid;
  asr_pkg::rhs_item_t  s2_item;
  logic                s3_valid;
  logic signed [PW-1:0] s3_px;
  logic signed [PW-1:0] s3_py;
  logic                s3_central;
  asr_pkg::row_idx_t   s3_row;
  asr_pkg::col_idx_t   s3_col;
  logic                s3_last;
  logic                o_valid;
  logic                en3;
  logic                en_out;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] shifted;

  assign en_out   = !o_valid || result.ready;
  assign en3      = !s3_valid || en_out;
  assign in_ready = !s2_valid || en3;

  assign sum     = SW'(s3_px) + SW'(s3_py);
  assign acc     = -sum;
  assign shifted = s3_central ? (acc >>> asr_pkg::SHIFT_CENTRAL)
                              : (acc >>> asr_pkg::SHIFT_UPWIND);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        s2_valid <= in_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
      if (en_out) begin
        o_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s2_item <= in_item;
    end
    if (en3 && s2_valid) begin
      s3_px      <= PW'(coef_x) * PW'(s2_item.dxd);
      s3_py      <= PW'(coef_y) * PW'(s2_item.dyd);
      s3_central <= s2_item.central;
      s3_row     <= s2_item.row_index;
      s3_col     <= s2_item.col_index;
      s3_last    <= s2_item.last;
    end
    if (en_out && s3_valid) begin
      result.rhs_value <= shifted[31:0];
      result.row_index <= s3_row;
      result.col_index <= s3_col;
      result.last      <= s3_last;
    end
  end

  assign result.valid = o_valid;

endmodule

FILE: hdl/advection_stencil_rhs_core.sv
// ----------------------------------------------------------------------------
// advection_stencil_rhs_core
// Raster-stream advection right-hand side, upwind or central difference.
// ----------------------------------------------------------------------------
//  channel     dir  handshake         payload
//  sample_ch   in   valid/ready       sample
//  result_ch   out  valid/ready       rhs_value, row_index, col_index, last
//  apb         in   psel/penable      scheme_mode, coef_x, coef_y, row/col_count
//
//  One sample per cycle while results are not stalled; a result passes s1,
//  s2, s3 and the output register after its lower-right neighbor sample is taken.
//  Line buffers are registered-read RAMs, read at accept, used at the read stage.
//  Reset (rst, synchronous) clears counters, window and pipeline valids.
//  A stalled result backs up the pipeline stage by stage; bubbles collapse.
// ----------------------------------------------------------------------------
module advection_stencil_rhs_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  asr_sample_if.sink                  sample_ch,
  asr_result_if.source                result_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asr_pkg::APB_AW-1:0]  paddr,
  input  logic [asr_pkg::APB_DW-1:0]  pwdata,
  output logic [asr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CCW = (CW + 1 > $bits(asr_pkg::col_cnt_t)) ? CW + 1
                                                            : $bits(asr_pkg::col_cnt_t);
  localparam int RCW = (RW + 1 > $bits(asr_pkg::row_cnt_t)) ? RW + 1
                                                            : $bits(asr_pkg::row_cnt_t);

  logic               scheme_mode;
  asr_pkg::coef_t     coef_x;
  asr_pkg::coef_t     coef_y;
  asr_pkg::row_cnt_t  row_count;
  asr_pkg::col_cnt_t  col_count;

  logic [RCW-1:0]     rows_eff;
  logic [CCW-1:0]     cols_eff;
  logic [RCW-1:0]     row_ext;
  logic [CCW-1:0]     col_ext;
  logic [RCW-1:0]     row_inc;
  logic [CCW-1:0]     col_inc;
  logic [RCW-1:0]     row_m1;
  logic [CCW-1:0]     col_m1;

  logic [RW-1:0]      row_counter;
  logic [CW-1:0]      col_counter;

  logic               accept;
  logic               cfg_wr;
  logic               hit;

  logic               s1_valid;
  asr_pkg::sample_t   s1_sample;
  logic [CW-1:0]      s1_col;
  logic               s1_hit;
  asr_pkg::row_idx_t  s1_row_index;
  asr_pkg::col_idx_t  s1_col_index;
  logic               s1_last;
  logic               s1_adv;

  asr_pkg::sample_t   lo_cur;
  asr_pkg::sample_t   mid_prev;
  asr_pkg::sample_t   mid_cur;
  asr_pkg::sample_t   up_cur;
  asr_pkg::sample_t   mid_line;
  asr_pkg::sample_t   up_line;

  asr_pkg::rhs_item_t pipe_item;
  logic               pipe_valid;
  logic               pipe_ready;
  logic               pos_x;
  logic               pos_y;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scheme_mode <= 1'b0;
      coef_x      <= '0;
      coef_y      <= '0;
      row_count   <= asr_pkg::row_cnt_t'(asr_pkg::MIN_DIM);
      col_count   <= asr_pkg::col_cnt_t'(asr_pkg::MIN_DIM);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        asr_pkg::REG_SCHEME_MODE: scheme_mode <= pwdata[0];
        asr_pkg::REG_COEF_X:      coef_x      <= pwdata[23:0];
        asr_pkg::REG_COEF_Y:      coef_y      <= pwdata[23:0];
        asr_pkg::REG_ROW_COUNT:   row_count   <= pwdata[10:0];
        asr_pkg::REG_COL_COUNT:   col_count   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      asr_pkg::REG_SCHEME_MODE: prdata = {31'd0, scheme_mode};
      asr_pkg::REG_COEF_X:      prdata = {{8{coef_x[23]}}, coef_x};
      asr_pkg::REG_COEF_Y:      prdata = {{8{coef_y[23]}}, coef_y};
      asr_pkg::REG_ROW_COUNT:   prdata = {21'd0, row_count};
      asr_pkg::REG_COL_COUNT:   prdata = {23'd0, col_count};
      default:                  prdata = '0;
    endcase
  end

  // frame geometry, clamped
  always_comb begin
    rows_eff = RCW'(row_count);
    if (rows_eff < RCW'(asr_pkg::MIN_DIM)) begin
      rows_eff = RCW'(asr_pkg::MIN_DIM);
    end else if (rows_eff > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end
    cols_eff = CCW'(col_count);
    if (cols_eff < CCW'(asr_pkg::MIN_DIM)) begin
      cols_eff = CCW'(asr_pkg::MIN_DIM);
    end else if (cols_eff > CCW'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end
  end

  assign row_ext = RCW'(row_counter);
  assign col_ext = CCW'(col_counter);
  assign row_inc = row_ext + RCW'(1);
  assign col_inc = col_ext + CCW'(1);
  assign row_m1  = row_ext - RCW'(1);
  assign col_m1  = col_ext - CCW'(1);
  assign hit     = (row_ext >= RCW'(2)) && (col_ext >= CCW'(2)) &&
                   (row_ext < rows_eff) && (col_ext < cols_eff);

  assign accept          = sample_ch.valid && sample_ch.ready;
  assign s1_adv          = s1_valid && pipe_ready;
  assign sample_ch.ready = !s1_valid || pipe_ready;

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (accept) begin
      if (col_inc >= cols_eff) begin
        col_counter <= '0;
        if (row_inc >= rows_eff) begin
          row_counter <= '0;
        end else begin
          row_counter <= row_inc[RW-1:0];
        end
      end else begin
        col_counter <= col_inc[CW-1:0];
      end
    end
  end

  // line buffer read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      s1_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample    <= sample_ch.sample;
      s1_col       <= col_counter;
      s1_hit       <= hit;
      s1_row_index <= row_m1[9:0];
      s1_col_index <= col_m1[7:0];
      s1_last      <= (row_ext == rows_eff - RCW'(1)) && (col_ext == cols_eff - CCW'(1));
    end
  end

  // stencil rows: lower -> middle -> upper
  asr_cell #(.DEPTH(MAX_COLS), .HAS_LINE(1'b1)) u_cell_lo (
    .clk      (clk),
    .rst      (rst),
    .adv      (s1_adv),
    .wr_addr  (s1_col),
    .rd_en    (accept),
    .rd_addr  (col_counter),
    .din      (s1_sample),
    .tap_prev (),
    .tap_cur  (lo_cur),
    .line_out (mid_line)
  );

  asr_cell #(.DEPTH(MAX_COLS), .HAS_LINE(1'b1)) u_cell_mid (
    .clk      (clk),
    .rst      (rst),
    .adv      (s1_adv),
    .wr_addr  (s1_col),
    .rd_en    (accept),
    .rd_addr  (col_counter),
    .din      (mid_line),
    .tap_prev (mid_prev),
    .tap_cur  (mid_cur),
    .line_out (up_line)
  );

  asr_cell #(.DEPTH(MAX_COLS), .HAS_LINE(1'b0)) u_cell_up (
    .clk      (clk),
    .rst      (rst),
    .adv      (s1_adv),
    .wr_addr  (s1_col),
    .rd_en    (accept),
    .rd_addr  (col_counter),
    .din      (up_line),
    .tap_prev (),
    .tap_cur  (up_cur),
    .line_out ()
  );

  // difference selection
  assign pos_x = !coef_x[23] && (coef_x != '0);
  assign pos_y = !coef_y[23] && (coef_y != '0);

  always_comb begin
    pipe_item.central   = scheme_mode;
    pipe_item.row_index = s1_row_index;
    pipe_item.col_index = s1_col_index;
    pipe_item.last      = s1_last;
    if (scheme_mode) begin
      pipe_item.dxd = asr_pkg::diff_t'(lo_cur) - asr_pkg::diff_t'(up_cur);
      pipe_item.dyd = asr_pkg::diff_t'(mid_line) - asr_pkg::diff_t'(mid_prev);
    end else begin
      pipe_item.dxd = pos_x ? asr_pkg::diff_t'(mid_cur) - asr_pkg::diff_t'(up_cur)
                            : asr_pkg::diff_t'(lo_cur) - asr_pkg::diff_t'(mid_cur);
      pipe_item.dyd = pos_y ? asr_pkg::diff_t'(mid_cur) - asr_pkg::diff_t'(mid_prev)
                            : asr_pkg::diff_t'(mid_line) - asr_pkg::diff_t'(mid_cur);
    end
  end

  assign pipe_valid = s1_valid && s1_hit;

  asr_rhs_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .coef_x   (coef_x),
    .coef_y   (coef_y),
    .in_valid (pipe_valid),
    .in_ready (pipe_ready),
    .in_item  (pipe_item),
    .result   (result_ch)
  );

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted sample did not reach the read stage");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !pipe_ready |=> s1_valid && $stable(s1_col) && $stable(s1_sample))
    else $error("read stage lost its transaction while stalled");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !pipe_ready |-> !sample_ch.ready)
    else $error("sample accepted while read stage blocked");

  a_window_static_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(mid_cur) && $stable(mid_prev))
    else $error("window moved without a transaction");

endmodule
